[hw/rtl/omfpse_pkg.sv]
// Shared types and constants for the OMF public symbol extractor.
// Used by the record parser, the top level and the port checker; depends on nothing.
`default_nettype none

package omfpse_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_TOO_LONG     = 3'd0;
   localparam logic [2:0] ERR_INDEX_SHORT  = 3'd1;
   localparam logic [2:0] ERR_PUBDEF_SHORT = 3'd2;
   localparam logic [2:0] ERR_IMPDEF_SHORT = 3'd3;
   localparam logic [2:0] ERR_ALIAS_SHORT  = 3'd4;

   // Record types and IMPDEF comment markers.
   localparam logic [7:0] REC_PUBDEF   = 8'h90;
   localparam logic [7:0] REC_PUBDEF32 = 8'h91;
   localparam logic [7:0] REC_ALIAS    = 8'hC6;
   localparam logic [7:0] REC_COMENT   = 8'h88;
   localparam logic [7:0] REC_MODEND   = 8'h8A;
   localparam logic [7:0] REC_MODEND32 = 8'h8B;
   localparam logic [7:0] IMP_CLASS    = 8'hA0;
   localparam logic [7:0] IMP_SUBTYPE  = 8'h01;

   // Largest record body length that is walked.
   localparam logic [15:0] MAX_RECORD_BYTES = 16'd1024;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] name_byte;
      logic [2:0] error_code;
   } rsp_item_type;

   // Results produced by one parse step, slot 0 first.
   typedef struct packed {
      logic [1:0]                count;
      rsp_item_type [1:0]        slot;
   } emit_type;

endpackage

`default_nettype wire

[hw/rtl/omfpse_parser.sv]
// Record walker: holds the parse state and turns one stream byte into up to two results.
// Depends on omfpse_pkg.
`default_nettype none

module omfpse_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_valid,
   input  wire logic                step_kind,
   input  wire logic [7:0]          step_byte,
   output omfpse_pkg::emit_type     emit
);
   import omfpse_pkg::*;

   localparam logic [4:0] PH_TYPE   = 5'd0;
   localparam logic [4:0] PH_LENLO  = 5'd1;
   localparam logic [4:0] PH_LENHI  = 5'd2;
   localparam logic [4:0] PH_SKIP   = 5'd3;
   localparam logic [4:0] PH_GIDX   = 5'd4;
   localparam logic [4:0] PH_GIDX2  = 5'd5;
   localparam logic [4:0] PH_SIDX   = 5'd6;
   localparam logic [4:0] PH_SIDX2  = 5'd7;
   localparam logic [4:0] PH_FRAME  = 5'd8;
   localparam logic [4:0] PH_NLEN   = 5'd9;
   localparam logic [4:0] PH_NAME   = 5'd10;
   localparam logic [4:0] PH_OFF    = 5'd11;
   localparam logic [4:0] PH_TIDX   = 5'd12;
   localparam logic [4:0] PH_TIDX2  = 5'd13;
   localparam logic [4:0] PH_ALEN   = 5'd14;
   localparam logic [4:0] PH_ANAME  = 5'd15;
   localparam logic [4:0] PH_CB0    = 5'd16;
   localparam logic [4:0] PH_CCLASS = 5'd17;
   localparam logic [4:0] PH_CSUB   = 5'd18;
   localparam logic [4:0] PH_CB3    = 5'd19;
   localparam logic [4:0] PH_CLEN   = 5'd20;
   localparam logic [4:0] PH_CNAME  = 5'd21;

   logic [4:0]  phase_ff, phase_in;
   logic [7:0]  rec_code_ff, rec_code_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic [15:0] body_ff, body_in;
   logic [7:0]  name_rem_ff, name_rem_in;
   logic [2:0]  skip_ff, skip_in;
   logic        seg_zero_ff, seg_zero_in;
   logic        halted_ff, halted_in;

   // Another name follows only if bytes other than the checksum remain.
   function automatic logic [4:0] name_loop(input logic [15:0] avail);
      name_loop = (avail == 16'd0) ? PH_SKIP : PH_NLEN;
   endfunction

   always_comb begin
      logic [15:0] remain;
      logic [15:0] avail;
      logic [15:0] hdr_len;
      logic [16:0] byte_ext;
      logic [2:0]  skip_dec;
      logic [7:0]  name_dec;
      logic [2:0]  off_len;
      logic        seg_zero;
      logic        do_name, do_accept, do_error, do_end;
      logic [2:0]  err_code;
      logic [1:0]  cnt;

      phase_in    = phase_ff;
      rec_code_in = rec_code_ff;
      rec_len_in  = rec_len_ff;
      body_in     = body_ff;
      name_rem_in = name_rem_ff;
      skip_in     = skip_ff;
      seg_zero_in = seg_zero_ff;
      halted_in   = halted_ff;

      remain   = body_ff - 16'd1;
      avail    = (remain == 16'd0) ? 16'd0 : remain - 16'd1;
      hdr_len  = {step_byte, rec_len_ff[7:0]};
      byte_ext = {9'd0, step_byte};
      skip_dec = skip_ff - 3'd1;
      name_dec = name_rem_ff - 8'd1;
      off_len  = (rec_code_ff == REC_PUBDEF32) ? 3'd4 : 3'd2;
      seg_zero = 1'b0;
      do_name   = 1'b0;
      do_accept = 1'b0;
      do_error  = 1'b0;
      do_end    = 1'b0;
      err_code  = ERR_TOO_LONG;

      if (step_valid) begin
         if (step_kind) begin
            phase_in    = PH_TYPE;
            rec_code_in = 8'd0;
            rec_len_in  = 16'd0;
            body_in     = 16'd0;
            name_rem_in = 8'd0;
            skip_in     = 3'd0;
            seg_zero_in = 1'b0;
            halted_in   = 1'b0;
         end else if (!halted_ff) begin
            case (phase_ff)
               PH_TYPE: begin
                  rec_code_in = step_byte;
                  phase_in    = PH_LENLO;
               end
               PH_LENLO: begin
                  rec_len_in = {8'd0, step_byte};
                  phase_in   = PH_LENHI;
               end
               PH_LENHI: begin
                  rec_len_in = hdr_len;
                  if (hdr_len > MAX_RECORD_BYTES) begin
                     do_error = 1'b1;
                     err_code = ERR_TOO_LONG;
                  end else begin
                     body_in = hdr_len;
                     if (rec_code_ff == REC_PUBDEF || rec_code_ff == REC_PUBDEF32) begin
                        if (hdr_len < 16'd2) begin
                           do_error = 1'b1;
                           err_code = ERR_INDEX_SHORT;
                        end else begin
                           phase_in = PH_GIDX;
                        end
                     end else if (rec_code_ff == REC_ALIAS) begin
                        if (hdr_len == 16'd0) begin
                           do_error = 1'b1;
                           err_code = ERR_ALIAS_SHORT;
                        end else begin
                           phase_in = PH_ALEN;
                        end
                     end else if (rec_code_ff == REC_COMENT && hdr_len >= 16'd3) begin
                        phase_in = PH_CB0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                     // An empty record ends at its header.
                     if (!do_error && hdr_len == 16'd0) begin
                        if (rec_code_ff == REC_MODEND || rec_code_ff == REC_MODEND32) begin
                           do_end = 1'b1;
                        end else begin
                           phase_in = PH_TYPE;
                        end
                     end
                  end
               end
               default: begin
                  body_in = remain;
                  case (phase_ff)
                     PH_GIDX: begin
                        if (avail == 16'd0) begin
                           do_error = 1'b1;
                           err_code = ERR_INDEX_SHORT;
                        end else begin
                           phase_in = step_byte[7] ? PH_GIDX2 : PH_SIDX;
                        end
                     end
                     PH_GIDX2: begin
                        if (avail == 16'd0) begin
                           do_error = 1'b1;
                           err_code = ERR_INDEX_SHORT;
                        end else begin
                           phase_in = PH_SIDX;
                        end
                     end
                     PH_SIDX, PH_SIDX2: begin
                        if (phase_ff == PH_SIDX) begin
                           seg_zero = (step_byte[6:0] == 7'd0);
                        end else begin
                           seg_zero = seg_zero_ff && (step_byte == 8'd0);
                        end
                        seg_zero_in = seg_zero;
                        if (phase_ff == PH_SIDX && step_byte[7]) begin
                           if (avail == 16'd0) begin
                              do_error = 1'b1;
                              err_code = ERR_INDEX_SHORT;
                           end else begin
                              phase_in = PH_SIDX2;
                           end
                        end else if (!seg_zero) begin
                           phase_in = name_loop(avail);
                        end else if (avail < 16'd2) begin
                           do_error = 1'b1;
                           err_code = ERR_PUBDEF_SHORT;
                        end else begin
                           skip_in  = 3'd2;
                           phase_in = PH_FRAME;
                        end
                     end
                     PH_FRAME: begin
                        skip_in = skip_dec;
                        if (skip_dec == 3'd0) begin
                           phase_in = name_loop(avail);
                        end
                     end
                     PH_NLEN, PH_NAME: begin
                        if (phase_ff == PH_NAME) begin
                           do_name     = 1'b1;
                           name_rem_in = name_dec;
                        end
                        if (phase_ff == PH_NLEN && avail < byte_ext[15:0]) begin
                           do_error = 1'b1;
                           err_code = ERR_PUBDEF_SHORT;
                        end else if (phase_ff == PH_NLEN && step_byte != 8'd0) begin
                           name_rem_in = step_byte;
                           phase_in    = PH_NAME;
                        end else if (phase_ff == PH_NLEN || name_dec == 8'd0) begin
                           if (phase_ff == PH_NLEN) begin
                              name_rem_in = step_byte;
                           end
                           // The name is done: the offset follows.
                           if (avail < {13'd0, off_len}) begin
                              do_error = 1'b1;
                              err_code = ERR_PUBDEF_SHORT;
                           end else begin
                              skip_in  = off_len;
                              phase_in = PH_OFF;
                           end
                        end
                     end
                     PH_OFF: begin
                        skip_in = skip_dec;
                        if (skip_dec == 3'd0) begin
                           if (avail == 16'd0) begin
                              do_error = 1'b1;
                              err_code = ERR_INDEX_SHORT;
                           end else begin
                              phase_in = PH_TIDX;
                           end
                        end
                     end
                     PH_TIDX: begin
                        if (step_byte[7]) begin
                           if (avail == 16'd0) begin
                              do_error = 1'b1;
                              err_code = ERR_INDEX_SHORT;
                           end else begin
                              phase_in = PH_TIDX2;
                           end
                        end else begin
                           do_accept = 1'b1;
                           phase_in  = name_loop(avail);
                        end
                     end
                     PH_TIDX2: begin
                        do_accept = 1'b1;
                        phase_in  = name_loop(avail);
                     end
                     PH_ALEN: begin
                        if (byte_ext + 17'd2 > {1'b0, rec_len_ff}) begin
                           do_error = 1'b1;
                           err_code = ERR_ALIAS_SHORT;
                        end else begin
                           name_rem_in = step_byte;
                           if (step_byte == 8'd0) begin
                              do_accept = 1'b1;
                              phase_in  = PH_SKIP;
                           end else begin
                              phase_in = PH_ANAME;
                           end
                        end
                     end
                     PH_CB0: phase_in = PH_CCLASS;
                     PH_CCLASS: phase_in = (step_byte == IMP_CLASS) ? PH_CSUB : PH_SKIP;
                     PH_CSUB: begin
                        if (step_byte != IMP_SUBTYPE) begin
                           phase_in = PH_SKIP;
                        end else if (rec_len_ff < 16'd5) begin
                           do_error = 1'b1;
                           err_code = ERR_IMPDEF_SHORT;
                        end else begin
                           phase_in = PH_CB3;
                        end
                     end
                     PH_CB3: phase_in = PH_CLEN;
                     PH_CLEN: begin
                        if (byte_ext + 17'd5 > {1'b0, rec_len_ff}) begin
                           do_error = 1'b1;
                           err_code = ERR_IMPDEF_SHORT;
                        end else begin
                           name_rem_in = step_byte;
                           if (step_byte == 8'd0) begin
                              do_accept = 1'b1;
                              phase_in  = PH_SKIP;
                           end else begin
                              phase_in = PH_CNAME;
                           end
                        end
                     end
                     PH_ANAME, PH_CNAME: begin
                        do_name     = 1'b1;
                        name_rem_in = name_dec;
                        if (name_dec == 8'd0) begin
                           do_accept = 1'b1;
                           phase_in  = PH_SKIP;
                        end
                     end
                     default: phase_in = PH_SKIP;
                  endcase
                  // The record's last byte closes it unless the walk has stopped.
                  if (!do_error && remain == 16'd0) begin
                     if (rec_code_ff == REC_MODEND || rec_code_ff == REC_MODEND32) begin
                        do_end = 1'b1;
                     end else begin
                        phase_in = PH_TYPE;
                     end
                  end
               end
            endcase
            if (do_error || do_end) begin
               halted_in = 1'b1;
            end
         end
      end

      // Pack the results in the order the walk produces them.
      cnt       = 2'd0;
      emit.slot = '0;
      if (do_name) begin
         emit.slot[cnt[0]].out_kind  = KIND_NAME;
         emit.slot[cnt[0]].name_byte = step_byte;
         cnt = cnt + 2'd1;
      end
      if (do_accept) begin
         emit.slot[cnt[0]].out_kind = KIND_ACCEPT;
         cnt = cnt + 2'd1;
      end
      if (do_error) begin
         emit.slot[cnt[0]].out_kind   = KIND_ERROR;
         emit.slot[cnt[0]].error_code = err_code;
         cnt = cnt + 2'd1;
      end
      if (do_end) begin
         emit.slot[cnt[0]].out_kind = KIND_END;
         cnt = cnt + 2'd1;
      end
      emit.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         rec_code_ff <= 8'd0;
         rec_len_ff  <= 16'd0;
         body_ff     <= 16'd0;
         name_rem_ff <= 8'd0;
         skip_ff     <= 3'd0;
         seg_zero_ff <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         rec_code_ff <= rec_code_in;
         rec_len_ff  <= rec_len_in;
         body_ff     <= body_in;
         name_rem_ff <= name_rem_in;
         skip_ff     <= skip_in;
         seg_zero_ff <= seg_zero_in;
         halted_ff   <= halted_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/omf_public_symbol_extractor.sv]
// Top level of the OMF public symbol extractor: input register, record parser and result queue.
// Depends on omfpse_pkg and omfpse_parser.
`default_nettype none

// Walks an OMF object module fed one byte per req beat (req_kind high restarts the walk) and
// returns public names from PUBDEF, ALIAS and IMPDEF records as rsp beats: one beat per name
// character, an accept beat once the name's record fields check out, an error beat, or a
// module-end beat at MODEND; after an error or module end, bytes are dropped until a restart.
// The block takes one byte per cycle while req_stall is low. Each byte passes an input
// register and one combinational parse step, and its results land in a four-entry result queue.
// A byte yields two results when it is the last character of an ALIAS or IMPDEF name, or a
// PUBDEF name character whose following check fails, and the single result port then drains
// one result per cycle while rsp_stall is low; the input is held off while the queue has fewer
// than two free entries.
module omf_public_symbol_extractor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_data_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_out_kind,
   output      logic [7:0] rsp_name_byte,
   output      logic [2:0] rsp_error_code
);
   import omfpse_pkg::*;

   localparam int QueueDepth = 4;
   localparam int PtrBits    = $clog2(QueueDepth);

   logic                 stage_valid_ff, stage_valid_in;
   logic                 stage_kind_ff;
   logic [7:0]           stage_byte_ff;
   logic                 advance;
   logic                 take;
   logic                 pop;
   emit_type             emit;

   rsp_item_type         queue_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]     count_ff, count_in;
   logic [1:0]           push_cnt;

   // The staged byte moves on only when the queue can take both possible results.
   assign advance        = stage_valid_ff && (count_ff <= (PtrBits+1)'(QueueDepth - 2));
   assign req_stall      = stage_valid_ff && !advance;
   assign take           = req_valid && !req_stall;
   assign stage_valid_in = take || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_kind_ff <= req_kind;
         stage_byte_ff <= req_data_byte;
      end
   end

   omfpse_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_kind  (stage_kind_ff),
      .step_byte  (stage_byte_ff),
      .emit       (emit)
   );

   assign push_cnt  = advance ? emit.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_in = wr_ptr_ff + PtrBits'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
   assign count_in  = count_ff + (PtrBits+1)'(push_cnt) - (PtrBits+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= emit.slot[0];
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrBits'(1)] <= emit.slot[1];
      end
   end

   assign rsp_out_kind   = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_name_byte  = queue_ff[rd_ptr_ff].name_byte;
   assign rsp_error_code = queue_ff[rd_ptr_ff].error_code;

endmodule

`default_nettype wire

[hw/rtl/omfpse_port_checker.sv]
// Port-level checks for the OMF public symbol extractor, bound to its top level.
// Depends on omfpse_pkg and omf_public_symbol_extractor.
`default_nettype none

module omfpse_port_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_out_kind,
   input wire logic [7:0] rsp_name_byte,
   input wire logic [2:0] rsp_error_code
);
   import omfpse_pkg::*;

   // A result held back by the receiver stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_name_byte) && $stable(rsp_error_code))
      else $error("stalled result beat changed");

   // Only name beats carry a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == KIND_NAME || rsp_name_byte == 8'd0))
      else $error("non-name beat carries a character");

   // Only error beats carry a code, and codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_kind == KIND_ERROR || rsp_error_code == ERR_TOO_LONG)
         && rsp_error_code <= ERR_ALIAS_SHORT))
      else $error("bad error code on result beat");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat offered right after reset");

endmodule

bind omf_public_symbol_extractor omfpse_port_checker u_port_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_kind   (rsp_out_kind),
   .rsp_name_byte  (rsp_name_byte),
   .rsp_error_code (rsp_error_code)
);

`default_nettype wire
